>>> src/psc_pkg.sv
// Package for the PID speed controller with PWM outputs.
// Holds widths, register indexes, reset values, filter and drive constants.
// No dependencies; every other file in src imports it.
package psc_pkg;

  // Default encoder count width.
  localparam int COUNT_WIDTH_DEF = 12;

  // Fixed field widths.
  localparam int TARGET_W    = 14;
  localparam int GAIN_W      = 32;
  localparam int OUT_SPEED_W = 17;
  localparam int DUTY_W      = 8;
  localparam int ERR_SUM_W   = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_SPEED = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN   = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN   = CFG_INDEX_W'(3);

  // Register reset values.
  localparam logic [TARGET_W-1:0] TARGET_SPEED_RST = TARGET_W'(0);
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST    = GAIN_W'(83886);
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST   = GAIN_W'(201);
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST   = GAIN_W'(41943);

  // Speed scaling: count * 75 / 4.
  localparam int SPEED_MUL   = 75;
  localparam int SPEED_SHIFT = 2;

  // Low-pass filter: level = level*65025/65536 + 511*speed, 16 fraction bits (Q18.16 at default width).
  localparam int FILTER_KEEP  = 65025;
  localparam int FILTER_GAIN  = 511;
  localparam int FILTER_SHIFT = 16;

  // Drive: Q24 fixed point, clamped around the PWM midpoint.
  localparam int Q_FRAC        = 24;
  localparam int DUTY_MID      = 75;
  localparam int DRIVE_LIMIT_I = 75;
  localparam int DRIVE_CLIP_I  = 74;
  localparam int CLAMP_W       = 32;

  // Width of the raw speed for a given count width.
  function automatic int speed_width(int count_w);
    return count_w + 5;
  endfunction

  // Width of the filter level: 16 fraction bits, Q18.16 at the default count width.
  function automatic int level_width(int count_w);
    return speed_width(count_w) + FILTER_SHIFT + 1;
  endfunction

  // Width of the control error (target minus speed).
  function automatic int error_width(int count_w);
    int sw;
    sw = speed_width(count_w);
    return ((sw > TARGET_W + 1) ? sw : TARGET_W + 1) + 1;
  endfunction

endpackage

>>> src/psc_count_if.sv
// Input channel of the speed controller: one encoder count per item.
// Depends on psc_pkg for the default count width.
interface psc_count_if import psc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] count_delta;

  modport source (output valid, output count_delta, input ready);
  modport sink   (input valid, input count_delta, output ready);
endinterface

>>> src/psc_result_if.sv
// Result channel of the speed controller: speeds and PWM compare values.
// Depends on psc_pkg for the field widths.
interface psc_result_if import psc_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [OUT_SPEED_W-1:0] speed_now;
  logic signed [OUT_SPEED_W-1:0] speed_smoothed;
  logic        [DUTY_W-1:0]      duty_forward;
  logic        [DUTY_W-1:0]      duty_reverse;

  modport source (output valid, output speed_now, output speed_smoothed,
                  output duty_forward, output duty_reverse, input ready);
  modport sink   (input valid, input speed_now, input speed_smoothed,
                  input duty_forward, input duty_reverse, output ready);
endinterface

>>> src/psc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on psc_pkg for the index and data widths.
interface psc_cfg_if import psc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/psc_drive.sv
// PID drive pipeline: gain products, Q24 sum, clamp and PWM compare values.
// Depends on psc_pkg and psc_result_if; fed by the state stage of the top level.
module psc_drive import psc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [speed_width(COUNT_WIDTH)-1:0]  speed,
  input  logic signed [speed_width(COUNT_WIDTH)-1:0]  smoothed,
  input  logic signed [error_width(COUNT_WIDTH)-1:0]  err,
  input  logic signed [error_width(COUNT_WIDTH):0]    err_delta,
  input  logic signed [ERR_SUM_W-1:0]                 err_sum,
  input  logic        [GAIN_W-1:0]                    prop_gain,
  input  logic        [GAIN_W-1:0]                    integ_gain_dt,
  input  logic        [GAIN_W-1:0]                    deriv_gain_over_dt,
  psc_result_if.source                                results
);

  localparam int SPEED_W = speed_width(COUNT_WIDTH);
  localparam int E_W     = error_width(COUNT_WIDTH);
  localparam int DE_W    = E_W + 1;
  localparam int P_W     = GAIN_W + 1 + E_W;
  localparam int D_W     = GAIN_W + 1 + DE_W;
  localparam int I_W     = GAIN_W + 1 + ERR_SUM_W;
  localparam int DRIVE_W = ((D_W > I_W) ? D_W : I_W) + 2;
  localparam int WHOLE_W = DUTY_W + 1;

  localparam logic signed [DRIVE_W-1:0] DRIVE_HI =
    DRIVE_W'(longint'(DRIVE_LIMIT_I) * (longint'(1) << Q_FRAC));
  localparam logic signed [DRIVE_W-1:0] DRIVE_LO = -DRIVE_HI;
  localparam logic signed [CLAMP_W-1:0] CLIP_HI  =
    CLAMP_W'(longint'(DRIVE_CLIP_I) * (longint'(1) << Q_FRAC));
  localparam logic signed [CLAMP_W-1:0] CLIP_LO  = -CLIP_HI;
  localparam logic signed [WHOLE_W-1:0] MID      = WHOLE_W'(DUTY_MID);

  // Stage handshake: a stage loads when it is empty or the next one moves.
  logic v2, v3, v4;
  logic rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || results.ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = rdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy2) v2 <= in_valid;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 2: the three gain products.
  logic signed [P_W-1:0]     p_term;
  logic signed [D_W-1:0]     d_term;
  logic signed [I_W-1:0]     i_term;
  logic signed [SPEED_W-1:0] s2_speed, s2_smoothed;

  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      p_term      <= P_W'($signed({1'b0, prop_gain})) * P_W'(err);
      d_term      <= D_W'($signed({1'b0, deriv_gain_over_dt})) * D_W'(err_delta);
      i_term      <= I_W'($signed({1'b0, integ_gain_dt})) * I_W'(err_sum);
      s2_speed    <= speed;
      s2_smoothed <= smoothed;
    end
  end

  // Stage 3: full-precision Q24 drive.
  logic signed [DRIVE_W-1:0] drive;
  logic signed [SPEED_W-1:0] s3_speed, s3_smoothed;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      drive       <= DRIVE_W'(p_term) + DRIVE_W'(d_term) + DRIVE_W'(i_term);
      s3_speed    <= s2_speed;
      s3_smoothed <= s2_smoothed;
    end
  end

  // Clamp the drive, then take the whole part for both compare values.
  logic signed [CLAMP_W-1:0] drive_clamped;
  logic signed [CLAMP_W-1:0] drive_neg;
  logic signed [WHOLE_W-1:0] whole_fwd, whole_rev;

  always_comb begin
    if (drive >= DRIVE_HI) begin
      drive_clamped = CLIP_HI;
    end else if (drive < DRIVE_LO) begin
      drive_clamped = CLIP_LO;
    end else begin
      drive_clamped = CLAMP_W'(drive);
    end
    drive_neg = -drive_clamped;
    whole_fwd = MID + WHOLE_W'(drive_clamped >>> Q_FRAC);
    whole_rev = MID + WHOLE_W'(drive_neg >>> Q_FRAC);
  end

  // Stage 4: result register.
  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      results.speed_now      <= OUT_SPEED_W'(s3_speed);
      results.speed_smoothed <= OUT_SPEED_W'(s3_smoothed);
      results.duty_forward   <= whole_fwd[DUTY_W-1:0];
      results.duty_reverse   <= whole_rev[DUTY_W-1:0];
    end
  end

  assign results.valid = v4;

endmodule

>>> src/pid_speed_controller_pwm_core.sv
// Top level of the PID speed controller with clamped PWM drive.
// Depends on psc_pkg, the three channel interfaces and psc_drive.
//
//   Channel   Direction  Handshake      Payload
//   counts    in         valid / ready  count_delta
//   results   out        valid / ready  speed_now, speed_smoothed, duty_forward, duty_reverse
//   cfg       in         valid / ready  index, data (always ready)
//
// One item is accepted per cycle unless results stall; the result passes stages 1 to 4.
// The controller state (filter level, error sum, last speed and error) is updated
// in the accept cycle, so the rate is set by that state feedback path.
// Reset clears the state, the pipeline and sets the gain registers to defaults.
// A stalled result stage holds; earlier stages keep filling, so input stays ready
// until every stage is full.
module pid_speed_controller_pwm_core import psc_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  psc_count_if.sink     counts,
  psc_result_if.source  results,
  psc_cfg_if.sink       cfg
);

  localparam int SPEED_W = speed_width(COUNT_WIDTH);
  localparam int LEVEL_W = level_width(COUNT_WIDTH);
  localparam int E_W     = error_width(COUNT_WIDTH);
  localparam int DE_W    = E_W + 1;
  localparam int SC_W    = COUNT_WIDTH + 7;
  localparam int KP_W    = LEVEL_W + FILTER_SHIFT + 1;
  localparam int SUM_W   = ERR_SUM_W + 1;

  localparam logic signed [SUM_W-1:0] SUM_HI =
    SUM_W'((longint'(1) << (ERR_SUM_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_LO =
    SUM_W'(-(longint'(1) << (ERR_SUM_W - 1)));

  // Configuration registers.
  logic [TARGET_W-1:0] target_speed;
  logic [GAIN_W-1:0]   prop_gain;
  logic [GAIN_W-1:0]   integ_gain_dt;
  logic [GAIN_W-1:0]   deriv_gain_over_dt;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed       <= TARGET_SPEED_RST;
      prop_gain          <= PROP_GAIN_RST;
      integ_gain_dt      <= INTEG_GAIN_RST;
      deriv_gain_over_dt <= DERIV_GAIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TARGET_SPEED: target_speed       <= cfg.data[TARGET_W-1:0];
        REG_PROP_GAIN:    prop_gain          <= cfg.data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain_dt      <= cfg.data[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain_over_dt <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state.
  logic signed [LEVEL_W-1:0]   filter_level;
  logic signed [SPEED_W-1:0]   last_speed;
  logic signed [ERR_SUM_W-1:0] error_sum;
  logic signed [E_W-1:0]       last_error;

  // Raw speed: count * 75 / 4, truncated toward zero.
  logic signed [SC_W-1:0]    scaled, scaled_bias;
  logic signed [SPEED_W-1:0] speed;

  always_comb begin
    scaled      = SC_W'(counts.count_delta) * SC_W'(SPEED_MUL);
    scaled_bias = scaled[SC_W-1] ? SC_W'((1 << SPEED_SHIFT) - 1) : SC_W'(0);
    speed       = SPEED_W'((scaled + scaled_bias) >>> SPEED_SHIFT);
  end

  // Low-pass filter on the previous speed, and its truncated whole part.
  logic signed [KP_W-1:0]    keep_prod;
  logic signed [LEVEL_W-1:0] filter_level_next, level_bias;
  logic signed [SPEED_W-1:0] smoothed;

  always_comb begin
    keep_prod         = KP_W'(filter_level) * KP_W'(FILTER_KEEP);
    filter_level_next = LEVEL_W'(keep_prod >>> FILTER_SHIFT)
                      + LEVEL_W'(last_speed) * LEVEL_W'(FILTER_GAIN);
    level_bias        = filter_level_next[LEVEL_W-1]
                      ? LEVEL_W'((1 << FILTER_SHIFT) - 1) : LEVEL_W'(0);
    smoothed          = SPEED_W'((filter_level_next + level_bias) >>> FILTER_SHIFT);
  end

  // Error, error step and saturating error sum.
  logic signed [TARGET_W:0]    target_s;
  logic signed [E_W-1:0]       err;
  logic signed [DE_W-1:0]      err_delta;
  logic signed [SUM_W-1:0]     sum_wide;
  logic signed [ERR_SUM_W-1:0] error_sum_next;

  always_comb begin
    target_s  = $signed({1'b0, target_speed});
    err       = E_W'(target_s) - E_W'(speed);
    err_delta = DE_W'(err) - DE_W'(last_error);
    sum_wide  = SUM_W'(error_sum) + SUM_W'(err);
    if (sum_wide > SUM_HI) begin
      error_sum_next = ERR_SUM_W'(SUM_HI);
    end else if (sum_wide < SUM_LO) begin
      error_sum_next = ERR_SUM_W'(SUM_LO);
    end else begin
      error_sum_next = ERR_SUM_W'(sum_wide);
    end
  end

  // Stage 1: state update on accept, and the input register of the drive path.
  logic                        s1_valid;
  logic                        drv_ready;
  logic                        accept;
  logic signed [SPEED_W-1:0]   s1_speed, s1_smoothed;
  logic signed [E_W-1:0]       s1_err;
  logic signed [DE_W-1:0]      s1_err_delta;
  logic signed [ERR_SUM_W-1:0] s1_err_sum;

  assign counts.ready = !s1_valid || drv_ready;
  assign accept       = counts.valid && counts.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      filter_level <= '0;
      last_speed   <= '0;
      error_sum    <= '0;
      last_error   <= '0;
    end else begin
      if (counts.ready) s1_valid <= counts.valid;
      if (accept) begin
        filter_level <= filter_level_next;
        last_speed   <= speed;
        error_sum    <= error_sum_next;
        last_error   <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_speed     <= speed;
      s1_smoothed  <= smoothed;
      s1_err       <= err;
      s1_err_delta <= err_delta;
      s1_err_sum   <= error_sum_next;
    end
  end

  psc_drive #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_drive (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (s1_valid),
    .in_ready           (drv_ready),
    .speed              (s1_speed),
    .smoothed           (s1_smoothed),
    .err                (s1_err),
    .err_delta          (s1_err_delta),
    .err_sum            (s1_err_sum),
    .prop_gain          (prop_gain),
    .integ_gain_dt      (integ_gain_dt),
    .deriv_gain_over_dt (deriv_gain_over_dt),
    .results            (results)
  );

endmodule
